// File: design/mowm_pkg.sv
// Shared widths and defaults for the max-of-window-minimums block.
`timescale 1ns / 1ps

package mowm_pkg;

  // Width of one sequence value and of a result's best minimum.
  localparam int VALUE_W = 31;

  // Width of the window size field of a result.
  localparam int WSIZE_W = 7;

  // Default for the longest sequence the block keeps.
  localparam int MAX_LEN_DEF = 64;

endpackage

// File: design/mowm_if.sv
// Valid/ready channel interfaces for the sequence input and the result output.
`timescale 1ns / 1ps

interface mowm_in_if;
  logic                         valid;
  logic                         ready;
  logic [mowm_pkg::VALUE_W-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mowm_out_if;
  logic                         valid;
  logic                         ready;
  logic [mowm_pkg::WSIZE_W-1:0] window_size;
  logic [mowm_pkg::VALUE_W-1:0] best_minimum;
  logic                         final_res;

  modport source (output valid, output window_size, output best_minimum,
                  output final_res, input ready);
  modport sink   (input valid, input window_size, input best_minimum,
                  input final_res, output ready);
endinterface

// File: design/max_of_window_minimums_unit.sv
// Top level: maximum of window minimums over a sequence, for every window size.
//
//   channel   direction  payload                                  transfer when
//   in_item   in         value[30:0], last                        valid && ready
//   out_res   out        window_size[6:0], best_minimum[30:0],    valid && ready
//                        final_res
//
// A value with no pops is tested, then pushed; each pop reads below, reads answer, writes.
// A closing value then drains the stack by pops, runs the suffix-maximum pass with a read
// and write per window size, and its results leave one per cycle unless out_res.ready stalls.
// Reset clears the control state and the answer valid flags at once (no clearing pass); the
// flags clear again after each final result. in_item.ready is low from a value's transfer
// until its work is done, or its last result is transferred; a stalled result holds.
`timescale 1ns / 1ps

module max_of_window_minimums_unit #(
  parameter int MAX_LEN = mowm_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mowm_in_if.sink           in_item,
  mowm_out_if.source        out_res
);

  localparam int VW = mowm_pkg::VALUE_W;
  localparam int WW = mowm_pkg::WSIZE_W;
  // Address width of the stores, and width of counts that reach MAX_LEN itself.
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,  // waiting for a value
    ST_TEST   = 7'b0000010,  // compare top of stack, then pop or push
    ST_BELOW  = 7'b0000100,  // entry below the popped one is read out
    ST_CREDIT = 7'b0001000,  // answer table entry is read out, update it
    ST_SFX_RD = 7'b0010000,  // suffix pass: read next lower entry
    ST_SFX_WR = 7'b0100000,  // suffix pass: write running maximum
    ST_OUT    = 7'b1000000   // present results, one per transfer
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   sc_r, sc_nxt;          // stack depth
  logic [CW-1:0]   cnt_r, cnt_nxt;        // values loaded in this sequence
  logic [CW-1:0]   right_r, right_nxt;    // right bound of spans (position or n)
  logic [CW-1:0]   k_r, k_nxt;            // suffix pass and output index
  logic            drain_r, drain_nxt;    // the stack is being drained
  logic            below_r, below_nxt;    // the popped entry had one below it
  logic [VW-1:0]   v_r, v_nxt;            // value being pushed
  logic            last_r, last_nxt;
  logic [VW-1:0]   top_val_r, top_val_nxt;
  logic [VW-1:0]   pop_val_r, pop_val_nxt;
  logic [VW-1:0]   run_r, run_nxt;        // running maximum of the suffix pass
  logic [AW-1:0]   slot_r, slot_nxt;      // answer table slot being credited

  // The stores. The answer table has a valid flag for each entry; a clear flag
  // reads as zero.
  logic [VW-1:0]   value_mem [MAX_LEN];
  logic [AW-1:0]   index_mem [MAX_LEN];
  logic [VW-1:0]   answer_mem [MAX_LEN];
  logic [MAX_LEN-1:0] ans_vld_r;

  logic            vs_we, vs_re;
  logic [AW-1:0]   vs_waddr, vs_raddr;
  logic [VW-1:0]   vs_wdata, vs_q;
  logic            is_we, is_re;
  logic [AW-1:0]   is_waddr, is_raddr, is_wdata, is_q;
  logic            ans_we, ans_re, ans_clr;
  logic [AW-1:0]   ans_waddr, ans_raddr;
  logic [VW-1:0]   ans_wdata, ans_q, ans_rd;
  logic            ans_vld_q;

  // Shared comparator: stack test, credit update and suffix maximum all use it.
  logic [VW-1:0]   cmp_a, cmp_b;
  logic            cmp_ge;

  logic [CW-1:0]   span_len;
  logic            is_final;

  assign ans_rd   = ans_vld_q ? ans_q : '0;
  assign cmp_ge   = (cmp_a >= cmp_b);
  assign is_final = ((k_r + CW'(1)) == right_r);
  assign span_len = below_r ? (right_r - CW'(is_q) - CW'(1)) : right_r;

  assign in_item.ready        = (state_r == ST_IDLE);
  assign out_res.valid        = (state_r == ST_OUT);
  assign out_res.window_size  = WW'(k_r) + WW'(1);
  assign out_res.best_minimum = ans_rd;
  assign out_res.final_res    = is_final;

  always_comb begin
    case (state_r)
      ST_CREDIT: begin
        cmp_a = ans_rd;
        cmp_b = pop_val_r;
      end
      ST_SFX_WR: begin
        cmp_a = ans_rd;
        cmp_b = run_r;
      end
      default: begin
        cmp_a = top_val_r;
        cmp_b = v_r;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    sc_nxt      = sc_r;
    cnt_nxt     = cnt_r;
    right_nxt   = right_r;
    k_nxt       = k_r;
    drain_nxt   = drain_r;
    below_nxt   = below_r;
    v_nxt       = v_r;
    last_nxt    = last_r;
    top_val_nxt = top_val_r;
    pop_val_nxt = pop_val_r;
    run_nxt     = run_r;
    slot_nxt    = slot_r;
    vs_we       = 1'b0;
    vs_waddr    = AW'(cnt_r);
    vs_wdata    = in_item.value;
    vs_re       = 1'b0;
    vs_raddr    = is_q;
    is_we       = 1'b0;
    is_waddr    = AW'(sc_r);
    is_wdata    = AW'(right_r);
    is_re       = 1'b0;
    is_raddr    = AW'(sc_r - CW'(2));
    ans_we      = 1'b0;
    ans_waddr   = slot_r;
    ans_wdata   = pop_val_r;
    ans_re      = 1'b0;
    ans_raddr   = AW'(span_len - CW'(1));
    ans_clr     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          v_nxt    = in_item.value;
          last_nxt = in_item.last;
          if (cnt_r < MAX_LEN) begin
            vs_we     = 1'b1;
            right_nxt = cnt_r;
            state_nxt = ST_TEST;
          end else if (in_item.last) begin
            // Sequence already full: this value only closes it.
            drain_nxt = 1'b1;
            right_nxt = cnt_r;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if ((sc_r != '0) && (drain_r || cmp_ge)) begin
          pop_val_nxt = top_val_r;
          sc_nxt      = sc_r - CW'(1);
          below_nxt   = (sc_r >= CW'(2));
          is_re       = (sc_r >= CW'(2));
          state_nxt   = ST_BELOW;
        end else if (drain_r) begin
          k_nxt     = right_r;
          run_nxt   = '0;
          state_nxt = ST_SFX_RD;
        end else begin
          is_we       = 1'b1;
          top_val_nxt = v_r;
          sc_nxt      = sc_r + CW'(1);
          cnt_nxt     = cnt_r + CW'(1);
          if (last_r) begin
            drain_nxt = 1'b1;
            right_nxt = cnt_r + CW'(1);
            state_nxt = ST_TEST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BELOW: begin
        ans_re    = 1'b1;
        slot_nxt  = ans_raddr;
        vs_re     = below_r;
        state_nxt = ST_CREDIT;
      end
      ST_CREDIT: begin
        ans_we = !cmp_ge;
        if (below_r) begin
          top_val_nxt = vs_q;
        end
        state_nxt = ST_TEST;
      end
      ST_SFX_RD: begin
        ans_re = 1'b1;
        if (k_r == '0) begin
          ans_raddr = '0;
          state_nxt = ST_OUT;
        end else begin
          ans_raddr = AW'(k_r - CW'(1));
          k_nxt     = k_r - CW'(1);
          state_nxt = ST_SFX_WR;
        end
      end
      ST_SFX_WR: begin
        run_nxt   = cmp_ge ? ans_rd : run_r;
        ans_we    = 1'b1;
        ans_waddr = AW'(k_r);
        ans_wdata = cmp_ge ? ans_rd : run_r;
        state_nxt = ST_SFX_RD;
      end
      ST_OUT: begin
        if (out_res.ready) begin
          if (is_final) begin
            ans_clr   = 1'b1;
            cnt_nxt   = '0;
            sc_nxt    = '0;
            k_nxt     = '0;
            drain_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // Fetch the next entry in the same cycle so results leave back to back.
            k_nxt     = k_r + CW'(1);
            ans_re    = 1'b1;
            ans_raddr = AW'(k_r + CW'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sc_r    <= '0;
      cnt_r   <= '0;
      right_r <= '0;
      k_r     <= '0;
      drain_r <= 1'b0;
      below_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      cnt_r   <= cnt_nxt;
      right_r <= right_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
      below_r <= below_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    last_r    <= last_nxt;
    top_val_r <= top_val_nxt;
    pop_val_r <= pop_val_nxt;
    run_r     <= run_nxt;
    slot_r    <= slot_nxt;
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (vs_we) begin
      value_mem[vs_waddr] <= vs_wdata;
    end
    if (vs_re) begin
      vs_q <= value_mem[vs_raddr];
    end
  end

  // Index stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (is_we) begin
      index_mem[is_waddr] <= is_wdata;
    end
    if (is_re) begin
      is_q <= index_mem[is_raddr];
    end
  end

  // Answer table: one write port, one registered read port. The read data holds
  // while no read is issued, which keeps a stalled result stable.
  always_ff @(posedge clk) begin
    if (ans_we) begin
      answer_mem[ans_waddr] <= ans_wdata;
    end
    if (ans_re) begin
      ans_q <= answer_mem[ans_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ans_vld_r <= '0;
      ans_vld_q <= 1'b0;
    end else begin
      if (ans_clr) begin
        ans_vld_r <= '0;
      end else if (ans_we) begin
        ans_vld_r[ans_waddr] <= 1'b1;
      end
      if (ans_re) begin
        ans_vld_q <= ans_vld_r[ans_raddr];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_item.ready && out_res.valid))
    else $error("input ready while a result is presented");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= cnt_r)
    else $error("stack deeper than the number of loaded values");

  a_out_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (sc_r == '0) && drain_r)
    else $error("results presented before the stack was drained");

  a_size_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && !out_res.final_res |=>
      out_res.valid && (out_res.window_size == $past(out_res.window_size) + WW'(1)))
    else $error("window sizes do not advance by one");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && out_res.final_res |=>
      in_item.ready && (cnt_r == '0))
    else $error("sequence state not cleared after the final result");
`endif

endmodule

// File: verif/tb_max_of_window_minimums_unit.sv
// Self-checking testbench for the max-of-window-minimums unit, with a queue-fed driver.
`timescale 1ns / 1ps

module tb_max_of_window_minimums_unit;

  localparam int VALUE_W      = mowm_pkg::VALUE_W;
  localparam int WSIZE_W      = mowm_pkg::WSIZE_W;
  localparam int MAX_LEN      = mowm_pkg::MAX_LEN_DEF;
  localparam int TARGET_ITEMS = 460;
  // The slowest correct run stays well under this limit, even with every
  // gap and every stall at its longest. The limit leaves a wide margin.
  localparam int CYCLE_LIMIT  = 200000;
  // The block returns to idle once its final result is transferred. This many
  // quiet cycles at the end catch any result that should not exist.
  localparam int TAIL_CYCLES  = 40;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Value styles for one random sequence.
  typedef enum int {
    STYLE_FULL,
    STYLE_NARROW,
    STYLE_EXTREME,
    STYLE_CLUSTER
  } value_style_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    int                 gap;
    bit                 hold;
  } seq_item_t;

  typedef struct {
    logic [WSIZE_W-1:0] window_size;
    logic [VALUE_W-1:0] best_minimum;
    logic               final_res;
  } window_result_t;

  logic clk;
  logic rst_n;

  mowm_in_if  in_ch ();
  mowm_out_if out_ch ();

  max_of_window_minimums_unit #(
    .MAX_LEN (MAX_LEN)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch.sink),
    .out_res (out_ch.source)
  );

  // Pending input transfers, filled once by the stimulus process.
  seq_item_t      stim_items[$];
  // Values of the sequence now loading, as the block keeps them.
  logic [VALUE_W-1:0] open_sequence[$];
  // Results the block still owes, oldest first.
  window_result_t due_results[$];

  int in_taken;
  int res_taken;
  int errors;
  int cycles;
  int seq_closed;
  int overlong_seqs;
  int longest_seq;

  // Driver state, owned by the falling-edge process.
  seq_item_t cur_item;
  bit        drv_busy;
  int        drv_gap;
  int        drv_seen;

  // Result-side stall state, also owned by the falling-edge process.
  int  sink_wait;
  int  sink_seen;
  bit  sink_calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction. Each value that the block accepts is added to the open
  // sequence, unless the sequence already holds MAX_LEN values, in which
  // case the block ignores it. A closing value then produces one result per
  // window size. The best minimum is found directly: every window start is
  // grown to the right with a running minimum, which is independent of the
  // stack scheme that the block uses.
  // ---------------------------------------------------------------------
  task automatic take_value(input logic [VALUE_W-1:0] value, input logic last);
    logic [VALUE_W-1:0] best[MAX_LEN];
    logic [VALUE_W-1:0] run_min;
    window_result_t     res;
    int                 n;
    if (open_sequence.size() < MAX_LEN) open_sequence.push_back(value);
    if (!last) return;
    n = open_sequence.size();
    foreach (best[i]) best[i] = '0;
    for (int s = 0; s < n; s++) begin
      run_min = open_sequence[s];
      for (int e = s; e < n; e++) begin
        if (open_sequence[e] < run_min) run_min = open_sequence[e];
        if (run_min > best[e - s]) best[e - s] = run_min;
      end
    end
    for (int k = 0; k < n; k++) begin
      res.window_size  = WSIZE_W'(k + 1);
      res.best_minimum = best[k];
      res.final_res    = (k + 1 == n);
      due_results.push_back(res);
    end
    seq_closed++;
    if (n > longest_seq) longest_seq = n;
    open_sequence.delete();
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(value_style_t style,
                                                    logic [VALUE_W-1:0] base);
    logic [VALUE_W-1:0] v;
    case (style)
      STYLE_FULL: begin
        v = VALUE_W'($urandom);
      end
      STYLE_NARROW: begin
        // Few distinct values, so that equal neighbors pop each other often.
        v = VALUE_W'($urandom_range(0, 7));
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = VALUE_MAX;
          2: v = VALUE_MAX - 1;
          default: v = VALUE_W'(1);
        endcase
      end
      default: begin
        v = base ^ VALUE_W'($urandom_range(0, 15));
      end
    endcase
    return v;
  endfunction

  // Queue one whole sequence. A calm sequence is sent back to back; a held
  // sequence waits until the block has returned every result it owes.
  task automatic add_sequence(input logic [VALUE_W-1:0] vals[$], input bit calm,
                              input bit hold);
    seq_item_t it;
    foreach (vals[i]) begin
      it.value = vals[i];
      it.last  = (i == vals.size() - 1);
      it.gap   = calm ? 0 : $urandom_range(0, 10);
      it.hold  = hold && (i == 0);
      stim_items.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus, reset and the end of the run.
  // ---------------------------------------------------------------------
  initial begin
    logic [VALUE_W-1:0] vals[$];
    logic [VALUE_W-1:0] base;
    value_style_t       style;
    int                 counted;
    int                 seq_idx;
    int                 len;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    in_taken      = 0;
    res_taken     = 0;
    errors        = 0;
    cycles        = 0;
    seq_closed    = 0;
    overlong_seqs = 0;
    longest_seq   = 0;
    drv_busy      = 1'b0;
    drv_gap       = 0;
    drv_seen      = 0;
    sink_wait     = 0;
    sink_seen     = 0;
    sink_calm     = 1'b0;

    // Directed part: one-value sequences at both ends of the range, a run
    // of equal values (a tie pops the stack), rising and falling runs, an
    // alternating pattern, and extremes around a zero.
    vals = '{VALUE_W'(0)};
    add_sequence(vals, 1'b0, 1'b0);
    vals = '{VALUE_MAX};
    add_sequence(vals, 1'b1, 1'b1);
    vals = '{VALUE_W'(5), VALUE_W'(5), VALUE_W'(5)};
    add_sequence(vals, 1'b1, 1'b0);
    vals = '{VALUE_W'(1), VALUE_W'(2), VALUE_W'(3), VALUE_W'(4)};
    add_sequence(vals, 1'b0, 1'b0);
    vals = '{VALUE_W'(4), VALUE_W'(3), VALUE_W'(2), VALUE_W'(1)};
    add_sequence(vals, 1'b1, 1'b0);
    vals = '{VALUE_W'(3), VALUE_W'(1), VALUE_W'(3), VALUE_W'(1), VALUE_W'(3)};
    add_sequence(vals, 1'b0, 1'b1);
    vals = '{VALUE_MAX, VALUE_W'(0), VALUE_MAX};
    add_sequence(vals, 1'b0, 1'b0);
    counted = 21;

    // Random part. Most sequences are short. At least one fills the block
    // exactly, and at least one runs past the limit so that the block drops
    // its extra values; the dropped values do not count toward the item total.
    seq_idx = 0;
    while (counted < TARGET_ITEMS) begin
      if (seq_idx == 2 || $urandom_range(0, 39) == 0) begin
        len = MAX_LEN;
      end else if (seq_idx == 5 || $urandom_range(0, 39) == 0) begin
        len = MAX_LEN + $urandom_range(1, 6);
      end else begin
        len = $urandom_range(1, 12);
      end
      if (len > MAX_LEN) overlong_seqs++;
      style = value_style_t'($urandom_range(0, 3));
      base  = VALUE_W'($urandom);
      vals.delete();
      for (int i = 0; i < len; i++) vals.push_back(pick_value(style, base));
      add_sequence(vals, ($urandom_range(0, 3) == 0), ($urandom_range(0, 5) == 0));
      counted += (len > MAX_LEN) ? MAX_LEN : len;
      seq_idx++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (stim_items.size() > 0 || drv_busy) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Closed %0d sequences (longest %0d values, %0d past the length limit).",
             seq_closed, longest_seq, overlong_seqs);
    $display("Transferred %0d values in and checked %0d window results.",
             in_taken, res_taken);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. An item leaves the queue
  // when it becomes current, and stays current until its transfer is seen.
  // Its gap is counted down first; a held item also waits for the block to
  // owe nothing. Valid and each payload bit get one assignment per edge,
  // so back-to-back items keep valid high without a glitch.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.last  <= 1'b0;
    end else begin
      if (in_taken != drv_seen) begin
        drv_seen = in_taken;
        drv_busy = 1'b0;
      end
      if (!drv_busy && stim_items.size() > 0) begin
        cur_item = stim_items.pop_front();
        drv_busy = 1'b1;
        drv_gap  = cur_item.gap;
      end
      if (drv_busy && cur_item.hold && due_results.size() > 0) begin
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
      end else if (drv_busy && drv_gap == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= cur_item.value;
        in_ch.last  <= cur_item.last;
      end else begin
        if (drv_busy) drv_gap--;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
      end
    end
  end

  // Result-side back pressure. Before each result the sink waits a random
  // number of cycles; now and then it switches into a calm stretch with no
  // stalls at all.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (res_taken != sink_seen) begin
        sink_seen = res_taken;
        if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. A result is
  // checked against the oldest expectation before any new input is
  // predicted, which keeps the order right even on a shared edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        res_taken <= res_taken + 1;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: size %0d minimum %0d final %0b",
                   $time, out_ch.window_size, out_ch.best_minimum, out_ch.final_res);
        end else begin
          want = due_results.pop_front();
          if (out_ch.window_size !== want.window_size) begin
            errors++;
            $display("%0t: window_size expected %0d actual %0d", $time,
                     want.window_size, out_ch.window_size);
          end
          if (out_ch.best_minimum !== want.best_minimum) begin
            errors++;
            $display("%0t: best_minimum (size %0d) expected %0d actual %0d", $time,
                     want.window_size, want.best_minimum, out_ch.best_minimum);
          end
          if (out_ch.final_res !== want.final_res) begin
            errors++;
            $display("%0t: final_res (size %0d) expected %0b actual %0b", $time,
                     want.window_size, want.final_res, out_ch.final_res);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken <= in_taken + 1;
        take_value(in_ch.value, in_ch.last);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results still owed", $time,
               cycles, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
